### hw/rtl/ppid_pkg.sv
// Shared types, register codes and constants for the position PID block.
package ppid_pkg;

	localparam int DEADBAND_DEF = 5;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PPR        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DRIVE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ENC_REV    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_EN    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT  = 3'd7;

	localparam logic [15:0] MAX_DRIVE_RST = 16'd32767;
	localparam logic [14:0] INT_LIMIT_RST = 15'd500;

	localparam logic signed [31:0] INT32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;

	localparam int                REM_W        = 19;
	localparam logic [REM_W:0]    MDEG_PER_REV = 20'd360000;
	localparam int                DIV_BITS     = 4;
	localparam int                DIV_STEPS    = 32 / DIV_BITS;
	localparam int                DIV_CNT_W    = $clog2(DIV_STEPS);

	localparam logic [31:0] RECIP10_W    = 32'hCCCC_CCCD;
	localparam logic [31:0] RECIP10_N    = 32'd419431;

	localparam logic [1:0] TERM_P = 2'd0;
	localparam logic [1:0] TERM_I = 2'd1;
	localparam logic [1:0] TERM_D = 2'd2;

	typedef struct packed {
		logic signed [15:0] gain_p;
		logic signed [15:0] gain_i;
		logic signed [15:0] gain_d;
		logic [23:0]        ppr;
		logic [15:0]        max_drive;
		logic               enc_rev;
		logic               loop_en;
		logic [14:0]        int_limit;
	} cfg_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL,
		OP_DIV,
		OP_TICKS,
		OP_ERR,
		OP_AUX,
		OP_TSEL,
		OP_TREC,
		OP_TMUL,
		OP_TFRAC,
		OP_TACC,
		OP_FIN
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic       first;
		logic [1:0] term;
	} dp_cmd_t;

	typedef struct packed {
		logic skip;
		logic out_free;
	} dp_sts_t;

endpackage

### hw/rtl/ppid_regs.sv
// Configuration register file for the position PID block.
module ppid_regs import ppid_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p    <= '0;
			cfg_q.gain_i    <= '0;
			cfg_q.gain_d    <= '0;
			cfg_q.ppr       <= '0;
			cfg_q.max_drive <= MAX_DRIVE_RST;
			cfg_q.enc_rev   <= 1'b0;
			cfg_q.loop_en   <= 1'b0;
			cfg_q.int_limit <= INT_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_GAIN_P:    cfg_q.gain_p    <= $signed(cfg_data[15:0]);
				REG_GAIN_I:    cfg_q.gain_i    <= $signed(cfg_data[15:0]);
				REG_GAIN_D:    cfg_q.gain_d    <= $signed(cfg_data[15:0]);
				REG_PPR:       cfg_q.ppr       <= cfg_data[23:0];
				REG_MAX_DRIVE: cfg_q.max_drive <= cfg_data[15:0];
				REG_ENC_REV:   cfg_q.enc_rev   <= cfg_data[0];
				REG_LOOP_EN:   cfg_q.loop_en   <= cfg_data[0];
				REG_INT_LIMIT: cfg_q.int_limit <= cfg_data[14:0];
			endcase
		end
	end

endmodule

### hw/rtl/ppid_ctrl.sv
// Sequencer that steps the position PID datapath through one control tick.
module ppid_ctrl import ppid_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [11:0] {
		S_IDLE  = 12'b0000_0000_0001,
		S_MUL   = 12'b0000_0000_0010,
		S_DIV   = 12'b0000_0000_0100,
		S_TICKS = 12'b0000_0000_1000,
		S_ERR   = 12'b0000_0001_0000,
		S_AUX   = 12'b0000_0010_0000,
		S_TSEL  = 12'b0000_0100_0000,
		S_TREC  = 12'b0000_1000_0000,
		S_TMUL  = 12'b0001_0000_0000,
		S_TFRAC = 12'b0010_0000_0000,
		S_TACC  = 12'b0100_0000_0000,
		S_FIN   = 12'b1000_0000_0000
	} state_t;

	state_t               state_q, state_d;
	logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
	logic [1:0]           term_q, term_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		term_d    = term_q;
		cmd.op    = OP_NONE;
		cmd.first = (cnt_q == '0);
		cmd.term  = term_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.op  = OP_MUL;
				cnt_d   = '0;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.op = OP_DIV;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					state_d = S_TICKS;
				end
			end
			S_TICKS: begin
				cmd.op  = OP_TICKS;
				state_d = S_ERR;
			end
			S_ERR: begin
				cmd.op  = OP_ERR;
				state_d = S_AUX;
			end
			S_AUX: begin
				cmd.op = OP_AUX;
				term_d = TERM_P;
				if (sts.skip) begin
					state_d = S_FIN;
				end else begin
					state_d = S_TSEL;
				end
			end
			S_TSEL: begin
				cmd.op  = OP_TSEL;
				state_d = S_TREC;
			end
			S_TREC: begin
				cmd.op  = OP_TREC;
				state_d = S_TMUL;
			end
			S_TMUL: begin
				cmd.op  = OP_TMUL;
				state_d = S_TFRAC;
			end
			S_TFRAC: begin
				cmd.op  = OP_TFRAC;
				state_d = S_TACC;
			end
			S_TACC: begin
				cmd.op = OP_TACC;
				if (term_q == TERM_D) begin
					state_d = S_FIN;
				end else begin
					term_d  = term_q + 1'b1;
					state_d = S_TSEL;
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.op  = OP_FIN;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			term_q  <= TERM_P;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			term_q  <= term_d;
		end
	end

endmodule

### hw/rtl/ppid_dp.sv
// Datapath of the position PID block: shared multiplier, divider, terms and state.
module ppid_dp import ppid_pkg::*; #(
	parameter int DEADBAND = DEADBAND_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	input  cfg_t               cfg,
	input  logic signed [31:0] target_millideg,
	input  logic signed [31:0] encoder_count,
	input  logic               out_stall,
	output dp_sts_t            sts,
	output logic               out_valid,
	output logic signed [16:0] drive,
	output logic               in_tolerance,
	output logic               active
);

	localparam logic signed [32:0] DB_POS = 33'(DEADBAND);
	localparam logic signed [32:0] DB_NEG = -DB_POS;

	logic signed [31:0] angle_q, count_q;
	logic [31:0]        mul_a, mul_b;
	logic [63:0]        mul_p_q;
	logic               mul_en;

	logic [REM_W-1:0]    rem_q, div_r, rem_d;
	logic [REM_W:0]      div_rx;
	logic [31:0]         div_src, num_q, num_d;
	logic [DIV_BITS-1:0] div_qb;
	logic                ovf_q;

	logic [31:0]        ang_mag;
	logic signed [31:0] ticks_q, ticks_d, cnt_eff_q, cnt_eff_d;
	logic signed [32:0] diff;
	logic signed [31:0] err_q, err_d;
	logic               within_q, within_d;

	logic signed [33:0] isum_sum, lim34, nlim34, integ34;
	logic signed [15:0] integ_q;
	logic signed [32:0] deriv_q, deriv_d;

	logic signed [32:0] x_sel, x_neg_val;
	logic signed [15:0] g_sel;
	logic signed [16:0] g_ext, g_neg_val;
	logic [31:0]        x_mag_q, x_mag_d;
	logic [15:0]        gmag_q, gmag_d;
	logic               tneg_q, tneg_d;

	logic [28:0]        a_quo;
	logic [3:0]         ten4, b4;
	logic [19:0]        bg20;
	logic [REM_W-1:0]   bg_q;
	logic [44:0]        hi_q, term_mag;
	logic [15:0]        frac;
	logic signed [47:0] acc_q, acc_d, term48, md48;
	logic signed [16:0] drive_d;

	logic signed [15:0] isum_q;
	logic signed [31:0] last_err_q;
	logic               out_valid_q, intol_q, active_q;
	logic signed [16:0] drive_q;
	logic               skip;

	assign skip         = !cfg.loop_en || within_q;
	assign sts.skip     = skip;
	assign sts.out_free = !out_valid_q || !out_stall;
	assign out_valid    = out_valid_q;
	assign drive        = drive_q;
	assign in_tolerance = intol_q;
	assign active       = active_q;

	// shared multiplier operand select
	always_comb begin
		ang_mag = angle_q[31] ? (~angle_q + 32'd1) : angle_q;
		mul_en  = 1'b1;
		unique case (cmd.op)
			OP_MUL: begin
				mul_a = ang_mag;
				mul_b = {8'd0, cfg.ppr};
			end
			OP_TREC: begin
				mul_a = x_mag_q;
				mul_b = RECIP10_W;
			end
			OP_TMUL: begin
				mul_a = {3'd0, a_quo};
				mul_b = {16'd0, gmag_q};
			end
			OP_TFRAC: begin
				mul_a = {13'd0, bg_q};
				mul_b = RECIP10_N;
			end
			default: begin
				mul_a  = '0;
				mul_b  = '0;
				mul_en = 1'b0;
			end
		endcase
	end

	// radix-16 long division by the millidegrees per revolution
	always_comb begin
		div_r   = cmd.first ? mul_p_q[50:32] : rem_q;
		div_src = cmd.first ? mul_p_q[31:0] : num_q;
		div_rx  = '0;
		div_qb  = '0;
		for (int i = 0; i < DIV_BITS; i++) begin
			div_rx = {div_r, div_src[31-i]};
			if (div_rx >= MDEG_PER_REV) begin
				div_rx                 = div_rx - MDEG_PER_REV;
				div_qb[DIV_BITS-1-i]   = 1'b1;
			end
			div_r = div_rx[REM_W-1:0];
		end
		rem_d = div_r;
		num_d = {div_src[31-DIV_BITS:0], div_qb};
	end

	always_comb begin
		if (angle_q[31]) begin
			ticks_d = (ovf_q || (num_q > 32'h8000_0000)) ? INT32_MIN : $signed(~num_q + 32'd1);
		end else begin
			ticks_d = (ovf_q || num_q[31]) ? INT32_MAX : $signed(num_q);
		end
		if (cfg.enc_rev) begin
			cnt_eff_d = (count_q == INT32_MIN) ? INT32_MAX : -count_q;
		end else begin
			cnt_eff_d = count_q;
		end

		diff = {ticks_q[31], ticks_q} - {cnt_eff_q[31], cnt_eff_q};
		if (diff[32] != diff[31]) begin
			err_d = diff[32] ? INT32_MIN : INT32_MAX;
		end else begin
			err_d = diff[31:0];
		end
		within_d = (diff <= DB_POS) && (diff >= DB_NEG);

		isum_sum = {{18{isum_q[15]}}, isum_q} + {{2{err_q[31]}}, err_q};
		lim34    = {19'd0, cfg.int_limit};
		nlim34   = -lim34;
		priority if (isum_sum > lim34) begin
			integ34 = lim34;
		end else if (isum_sum < nlim34) begin
			integ34 = nlim34;
		end else begin
			integ34 = isum_sum;
		end
		deriv_d = {err_q[31], err_q} - {last_err_q[31], last_err_q};
	end

	always_comb begin
		unique case (cmd.term)
			TERM_P: begin
				x_sel = {err_q[31], err_q};
				g_sel = cfg.gain_p;
			end
			TERM_I: begin
				x_sel = {{17{integ_q[15]}}, integ_q};
				g_sel = cfg.gain_i;
			end
			TERM_D: begin
				x_sel = deriv_q;
				g_sel = cfg.gain_d;
			end
			default: begin
				x_sel = '0;
				g_sel = '0;
			end
		endcase
		x_neg_val = -x_sel;
		x_mag_d   = x_sel[32] ? x_neg_val[31:0] : x_sel[31:0];
		g_ext     = {g_sel[15], g_sel};
		g_neg_val = -g_ext;
		gmag_d    = g_sel[15] ? g_neg_val[15:0] : g_ext[15:0];
		tneg_d    = x_sel[32] ^ g_sel[15];

		// x = 10*a + b, so |x*g|/10 = a*|g| + (b*|g|)/10
		a_quo = mul_p_q[63:35];
		ten4  = {a_quo[0], 3'b000} + {a_quo[2:0], 1'b0};
		b4    = x_mag_q[3:0] - ten4;
		bg20  = 20'(b4) * 20'(gmag_q);

		frac     = mul_p_q[37:22];
		term_mag = hi_q + 45'(frac);
		term48   = $signed({3'd0, term_mag});
		acc_d    = tneg_q ? (acc_q - term48) : (acc_q + term48);

		md48 = $signed({32'd0, cfg.max_drive});
		priority if (acc_q > md48) begin
			drive_d = $signed({1'b0, cfg.max_drive});
		end else if (acc_q < -md48) begin
			drive_d = -$signed({1'b0, cfg.max_drive});
		end else begin
			drive_d = acc_q[16:0];
		end
	end

	always_ff @(posedge clk) begin
		if (mul_en) begin
			mul_p_q <= 64'(mul_a) * 64'(mul_b);
		end
		unique case (cmd.op)
			OP_LOAD: begin
				angle_q <= target_millideg;
				count_q <= encoder_count;
			end
			OP_DIV: begin
				rem_q <= rem_d;
				num_q <= num_d;
				if (cmd.first) begin
					ovf_q <= (mul_p_q[63:32] >= 32'(MDEG_PER_REV));
				end
			end
			OP_TICKS: begin
				ticks_q   <= ticks_d;
				cnt_eff_q <= cnt_eff_d;
			end
			OP_ERR: begin
				err_q    <= err_d;
				within_q <= within_d;
			end
			OP_AUX: begin
				integ_q <= integ34[15:0];
				deriv_q <= deriv_d;
				acc_q   <= '0;
			end
			OP_TSEL: begin
				x_mag_q <= x_mag_d;
				gmag_q  <= gmag_d;
				tneg_q  <= tneg_d;
			end
			OP_TMUL: begin
				bg_q <= bg20[REM_W-1:0];
			end
			OP_TFRAC: begin
				hi_q <= mul_p_q[44:0];
			end
			OP_TACC: begin
				acc_q <= acc_d;
			end
			OP_FIN: begin
				drive_q  <= skip ? '0 : drive_d;
				intol_q  <= within_q;
				active_q <= !skip;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			isum_q      <= '0;
			last_err_q  <= '0;
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_FIN) begin
			out_valid_q <= 1'b1;
			if (!skip) begin
				isum_q     <= integ_q;
				last_err_q <= err_q;
			end
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

### hw/rtl/position_pid_with_deadband.sv
// Top level of the position PID controller with dead band.
//
//   channel | signals                                        | direction
//   --------+------------------------------------------------+----------
//   in      | in_valid, in_stall, target_millideg,           | word in
//           | encoder_count                                  |
//   out     | out_valid, out_stall, drive, in_tolerance,     | word out
//           | active                                         |
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data      | write in
//
// A word that runs the loop works through the three gain terms; one in the dead band
// or with the loop disabled skips them. The next word can be accepted in the cycle
// after the result is loaded. The sequence is set by the single 32x32 multiplier, used
// three times per gain term, and by the radix-16 divider for the angle conversion.
// in_stall is high from accept until the result is loaded into the output register;
// a result waiting on out_stall holds the sequencer only at the final load.
// arst_n clears the sequencer, integral, last error and output valid, and resets the config registers.
module position_pid_with_deadband import ppid_pkg::*; #(
	parameter int DEADBAND = DEADBAND_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic signed [31:0]    target_millideg,
	input  logic signed [31:0]    encoder_count,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic signed [16:0]    drive,
	output logic                  in_tolerance,
	output logic                  active,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t    cfg;
	dp_cmd_t cmd;
	dp_sts_t sts;

	ppid_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ppid_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	ppid_dp #(
		.DEADBAND (DEADBAND)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cfg             (cfg),
		.target_millideg (target_millideg),
		.encoder_count   (encoder_count),
		.out_stall       (out_stall),
		.sts             (sts),
		.out_valid       (out_valid),
		.drive           (drive),
		.in_tolerance    (in_tolerance),
		.active          (active)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("accepted word did not hold off the input");

	a_idle_drive_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !active) |-> (drive == 17'sd0))
		else $error("inactive result carries nonzero drive");

	a_active_outside_band: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && active) |-> !in_tolerance)
		else $error("active result inside dead band");

	a_drive_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && active) |->
		((drive <= $signed({1'b0, cfg.max_drive})) &&
		 (drive >= -$signed({1'b0, cfg.max_drive}))))
		else $error("drive exceeds the magnitude limit");

endmodule
